/* design/v3a_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package v3a_pkg;

  localparam int DATA_W = 32;
  localparam int WIDE_W = 66;
  localparam int LEN2_W = 64;
  localparam int ROOT_W = 32;
  localparam int QUO_W = 33;
  localparam int SQRT_STAGES = 32;
  localparam int DIV_STAGES = QUO_W + 1;
  localparam int LANES = 3;

  localparam logic [2:0] OP_SCALE = 3'd0;
  localparam logic [2:0] OP_ADD = 3'd1;
  localparam logic [2:0] OP_SUB = 3'd2;
  localparam logic [2:0] OP_ADDS = 3'd3;
  localparam logic [2:0] OP_DOT = 3'd4;
  localparam logic [2:0] OP_CROSS = 3'd5;
  localparam logic [2:0] OP_NORM = 3'd6;

  localparam logic signed [WIDE_W-1:0] LIM_HI = 66'sd2147483647;
  localparam logic signed [WIDE_W-1:0] LIM_LO = -66'sd2147483648;
  localparam logic signed [DATA_W-1:0] OUT_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] OUT_MIN = 32'sh80000000;

  typedef struct packed {
    logic [2:0] func;
    logic signed [DATA_W-1:0] ax;
    logic signed [DATA_W-1:0] ay;
    logic signed [DATA_W-1:0] az;
    logic signed [DATA_W-1:0] bx;
    logic signed [DATA_W-1:0] by;
    logic signed [DATA_W-1:0] bz;
  } in_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] rx;
    logic signed [DATA_W-1:0] ry;
    logic signed [DATA_W-1:0] rz;
    logic saturated;
  } out_rsp_t;

  typedef struct packed {
    logic is_norm;
    logic zero;
    logic unit;
    logic sat;
    logic signed [DATA_W-1:0] rx;
    logic signed [DATA_W-1:0] ry;
    logic signed [DATA_W-1:0] rz;
    logic signed [DATA_W-1:0] ax;
    logic signed [DATA_W-1:0] ay;
    logic signed [DATA_W-1:0] az;
  } side_t;

  typedef struct packed {
    logic sat;
    logic signed [DATA_W-1:0] val;
  } clamp_t;

  function automatic clamp_t clamp32(input logic signed [WIDE_W-1:0] v);
    clamp_t c;
    if (v > LIM_HI) begin
      c.sat = 1'b1;
      c.val = OUT_MAX;
    end else if (v < LIM_LO) begin
      c.sat = 1'b1;
      c.val = OUT_MIN;
    end else begin
      c.sat = 1'b0;
      c.val = v[DATA_W-1:0];
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* design/v3a_lane.sv */
`timescale 1ns / 1ps
`default_nettype none
module v3a_lane import v3a_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [2:0]               func,
  input  wire logic signed [DATA_W-1:0] m0a,
  input  wire logic signed [DATA_W-1:0] m0b,
  input  wire logic signed [DATA_W-1:0] m1a,
  input  wire logic signed [DATA_W-1:0] m1b,
  input  wire logic signed [DATA_W-1:0] s0,
  input  wire logic signed [DATA_W-1:0] s1,
  output logic signed [LEN2_W-1:0]      res,
  output logic [LEN2_W-1:0]             sq
);

  logic signed [LEN2_W-1:0] p0_nxt, p1_nxt, p0_r, p1_r;
  logic signed [DATA_W-1:0] s0_r, s1_r;
  logic [2:0] func_r;
  logic signed [LEN2_W-1:0] res_nxt, res_r;
  logic [LEN2_W-1:0] sq_r;

  assign p0_nxt = m0a * m0b;
  assign p1_nxt = m1a * m1b;

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r <= p0_nxt;
      p1_r <= p1_nxt;
      s0_r <= s0;
      s1_r <= s1;
      func_r <= func;
    end
  end

  always_comb begin
    res_nxt = '0;
    unique case (func_r)
      OP_SCALE, OP_DOT: res_nxt = p0_r >>> FRAC_BITS;
      OP_CROSS: res_nxt = (p0_r >>> FRAC_BITS) - (p1_r >>> FRAC_BITS);
      OP_ADD, OP_ADDS: res_nxt = LEN2_W'(s0_r) + LEN2_W'(s1_r);
      OP_SUB: res_nxt = LEN2_W'(s0_r) - LEN2_W'(s1_r);
      default: res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      sq_r <= p0_r;
    end
  end

  assign res = res_r;
  assign sq = sq_r;

endmodule
`default_nettype wire

/* design/v3a_sqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
module v3a_sqrt import v3a_pkg::*; (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [LEN2_W-1:0] l2,
  output logic [ROOT_W-1:0]      root
);

  logic [LEN2_W-1:0] n_r [SQRT_STAGES];
  logic [LEN2_W-1:0] rt_r [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam logic [LEN2_W-1:0] BIT = LEN2_W'(1) << (62 - 2 * k);
    logic [LEN2_W-1:0] n_in, rt_in, t, n_nxt, rt_nxt;
    if (k == 0) begin : g_first
      assign n_in = l2;
      assign rt_in = '0;
    end else begin : g_next
      assign n_in = n_r[k-1];
      assign rt_in = rt_r[k-1];
    end
    always_comb begin
      t = rt_in + BIT;
      if (n_in >= t) begin
        n_nxt = n_in - t;
        rt_nxt = (rt_in >> 1) + BIT;
      end else begin
        n_nxt = n_in;
        rt_nxt = rt_in >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k] <= n_nxt;
        rt_r[k] <= rt_nxt;
      end
    end
  end

  assign root = rt_r[SQRT_STAGES-1][ROOT_W-1:0];

endmodule
`default_nettype wire

/* design/v3a_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module v3a_div import v3a_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic signed [DATA_W-1:0] c,
  input  wire logic [ROOT_W-1:0]        len,
  output logic [QUO_W-1:0]              q,
  output logic                          neg,
  output logic                          ovf
);

  localparam int DW = DATA_W + FRAC_BITS;
  localparam int HW = DW - QUO_W;

  logic [DATA_W-1:0] mag;
  logic [DW-1:0] dvd;
  logic [HW-1:0] hi;

  logic [ROOT_W-1:0] rem_r [DIV_STAGES];
  logic [QUO_W-1:0]  lo_r  [DIV_STAGES];
  logic [QUO_W-1:0]  q_r   [DIV_STAGES];
  logic [ROOT_W-1:0] len_r [DIV_STAGES];
  logic              neg_r [DIV_STAGES];
  logic              ovf_r [DIV_STAGES];

  assign mag = c[DATA_W-1] ? DATA_W'(-c) : DATA_W'(c);
  assign dvd = {mag, FRAC_BITS'(0)};
  assign hi = dvd[DW-1:QUO_W];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= ROOT_W'(hi);
      lo_r[0] <= dvd[QUO_W-1:0];
      q_r[0] <= '0;
      len_r[0] <= len;
      neg_r[0] <= c[DATA_W-1];
      ovf_r[0] <= ROOT_W'(hi) >= len;
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_iter
    logic [QUO_W-1:0] r2, diff;
    logic ge;
    always_comb begin
      r2 = {rem_r[k], lo_r[k][QUO_W-1]};
      diff = r2 - {1'b0, len_r[k]};
      ge = r2 >= {1'b0, len_r[k]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? diff[ROOT_W-1:0] : r2[ROOT_W-1:0];
        lo_r[k+1] <= lo_r[k] << 1;
        q_r[k+1] <= {q_r[k][QUO_W-2:0], ge};
        len_r[k+1] <= len_r[k];
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
    end
  end

  assign q = q_r[DIV_STAGES-1];
  assign neg = neg_r[DIV_STAGES-1];
  assign ovf = ovf_r[DIV_STAGES-1];

endmodule
`default_nettype wire

/* design/vec3_fixed_point_alu.sv */
// Three-component signed fixed-point vector unit.
// Requests arrive on in_valid/in_ready with payload in_req; each request gives
// exactly one result on out_valid/out_ready with payload out_rsp.
// Operations: scale, vector add, vector subtract, add scalar, dot product,
// cross product and normalize, selected by in_req.func.
// The unit is a fixed pipeline of 70 stages: two multiply stages in three
// component lanes, one merge stage, 32 square-root stages and 34 divider
// stages, then the output register. One request is taken every cycle while
// no result is waiting with out_ready held low.
// When the receiver holds out_ready low with a result waiting, the whole
// pipeline freezes and in_ready drops until that result is taken.
// Reset clears all valid flags; no result is presented after reset until a
// request has passed through the pipeline.
`timescale 1ns / 1ps
`default_nettype none
module vec3_fixed_point_alu import v3a_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_req_t  in_req,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_rsp_t      out_rsp
);

  localparam int SB_DEPTH = SQRT_STAGES + DIV_STAGES;

  logic en;
  logic v1_r, v2_r, v3_r;
  logic vsb_r [SB_DEPTH];
  logic out_valid_r;
  out_rsp_t out_rsp_r, out_rsp_nxt;
  in_req_t req1_r, req2_r;

  logic signed [DATA_W-1:0] a [LANES];
  logic signed [DATA_W-1:0] b [LANES];
  logic signed [LEN2_W-1:0] lres [LANES];
  logic [LEN2_W-1:0] lsq [LANES];

  assign en = !out_valid_r || out_ready;
  assign in_ready = en;

  assign a[0] = in_req.ax;
  assign a[1] = in_req.ay;
  assign a[2] = in_req.az;
  assign b[0] = in_req.bx;
  assign b[1] = in_req.by;
  assign b[2] = in_req.bz;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    localparam int J = (i + 1) % LANES;
    localparam int K = (i + 2) % LANES;
    logic signed [DATA_W-1:0] m0a, m0b, s1;
    always_comb begin
      m0a = (in_req.func == OP_CROSS) ? a[J] : a[i];
      if (in_req.func == OP_SCALE) begin
        m0b = in_req.bx;
      end else if (in_req.func == OP_CROSS) begin
        m0b = b[K];
      end else if (in_req.func == OP_NORM) begin
        m0b = a[i];
      end else begin
        m0b = b[i];
      end
      s1 = (in_req.func == OP_ADDS) ? in_req.bx : b[i];
    end
    v3a_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk  (clk),
      .en   (en),
      .func (in_req.func),
      .m0a  (m0a),
      .m0b  (m0b),
      .m1a  (b[J]),
      .m1b  (a[K]),
      .s0   (a[i]),
      .s1   (s1),
      .res  (lres[i]),
      .sq   (lsq[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      req1_r <= in_req;
      req2_r <= req1_r;
    end
  end

  // Merge stage: dot sum, clamping and the squared length.
  logic signed [WIDE_W-1:0] w0, w1, w2;
  clamp_t c0, c1, c2;
  logic [LEN2_W-1:0] l2_nxt, l2_r;
  side_t sb_nxt;
  side_t sb_r [SB_DEPTH];

  always_comb begin
    w0 = WIDE_W'(lres[0]);
    w1 = WIDE_W'(lres[1]);
    w2 = WIDE_W'(lres[2]);
    if (req2_r.func == OP_DOT) begin
      w0 = WIDE_W'(lres[0]) + WIDE_W'(lres[1]) + WIDE_W'(lres[2]);
      w1 = '0;
      w2 = '0;
    end else if (req2_r.func == OP_NORM) begin
      w0 = '0;
      w1 = '0;
      w2 = '0;
    end
    c0 = clamp32(w0);
    c1 = clamp32(w1);
    c2 = clamp32(w2);
    l2_nxt = lsq[0] + lsq[1] + lsq[2];
    sb_nxt.is_norm = (req2_r.func == OP_NORM);
    sb_nxt.zero = (l2_nxt == '0);
    sb_nxt.unit = (l2_nxt == (LEN2_W'(1) << (2 * FRAC_BITS)));
    sb_nxt.sat = c0.sat || c1.sat || c2.sat;
    sb_nxt.rx = c0.val;
    sb_nxt.ry = c1.val;
    sb_nxt.rz = c2.val;
    sb_nxt.ax = req2_r.ax;
    sb_nxt.ay = req2_r.ay;
    sb_nxt.az = req2_r.az;
  end

  side_t sb3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      l2_r <= l2_nxt;
      sb3_r <= sb_nxt;
      sb_r[0] <= sb3_r;
      for (int k = 1; k < SB_DEPTH; k++) begin
        sb_r[k] <= sb_r[k-1];
      end
    end
  end

  logic [ROOT_W-1:0] root;
  v3a_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .l2   (l2_r),
    .root (root)
  );

  logic signed [DATA_W-1:0] dc [LANES];
  logic [QUO_W-1:0] dq [LANES];
  logic dneg [LANES];
  logic dovf [LANES];
  clamp_t nc [LANES];

  assign dc[0] = sb_r[SQRT_STAGES-1].ax;
  assign dc[1] = sb_r[SQRT_STAGES-1].ay;
  assign dc[2] = sb_r[SQRT_STAGES-1].az;

  for (genvar i = 0; i < LANES; i++) begin : g_div
    logic signed [WIDE_W-1:0] qv;
    v3a_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk (clk),
      .en  (en),
      .c   (dc[i]),
      .len (root),
      .q   (dq[i]),
      .neg (dneg[i]),
      .ovf (dovf[i])
    );
    always_comb begin
      qv = WIDE_W'(dq[i]);
      if (dneg[i]) begin
        qv = -qv;
      end
      if (dovf[i]) begin
        nc[i].sat = 1'b1;
        nc[i].val = dneg[i] ? OUT_MIN : OUT_MAX;
      end else begin
        nc[i] = clamp32(qv);
      end
    end
  end

  side_t sbo;
  assign sbo = sb_r[SB_DEPTH-1];

  always_comb begin
    out_rsp_nxt.rx = sbo.rx;
    out_rsp_nxt.ry = sbo.ry;
    out_rsp_nxt.rz = sbo.rz;
    out_rsp_nxt.saturated = sbo.sat;
    if (sbo.is_norm) begin
      if (sbo.zero) begin
        out_rsp_nxt = '0;
      end else if (sbo.unit) begin
        out_rsp_nxt.rx = sbo.ax;
        out_rsp_nxt.ry = sbo.ay;
        out_rsp_nxt.rz = sbo.az;
        out_rsp_nxt.saturated = 1'b0;
      end else begin
        out_rsp_nxt.rx = nc[0].val;
        out_rsp_nxt.ry = nc[1].val;
        out_rsp_nxt.rz = nc[2].val;
        out_rsp_nxt.saturated = nc[0].sat || nc[1].sat || nc[2].sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rsp_r <= out_rsp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      for (int k = 0; k < SB_DEPTH; k++) begin
        vsb_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      vsb_r[0] <= v3_r;
      for (int k = 1; k < SB_DEPTH; k++) begin
        vsb_r[k] <= vsb_r[k-1];
      end
      out_valid_r <= vsb_r[SB_DEPTH-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp = out_rsp_r;

`ifndef SYNTHESIS
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");
  a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.saturated |->
      (out_rsp.rx == OUT_MAX || out_rsp.rx == OUT_MIN ||
       out_rsp.ry == OUT_MAX || out_rsp.ry == OUT_MIN ||
       out_rsp.rz == OUT_MAX || out_rsp.rz == OUT_MIN))
    else $error("saturated flag without a clamped component");
  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(vsb_r[SB_DEPTH-1]) && $stable(v3_r))
    else $error("pipeline moved while output stalled");
`endif

endmodule
`default_nettype wire
